// File: sv/multibit_trie_lookup_macros.svh
// Assertion macros used by the multibit trie lookup checker.
`ifndef MULTIBIT_TRIE_LOOKUP_MACROS_SVH
`define MULTIBIT_TRIE_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mtl_pkg.sv
// Types and constants of the multibit trie lookup block.
package mtl_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic signed [VALUE_W-1:0] NOT_FOUND_VALUE = -32'sd1;

    typedef struct packed {
        logic [1:0]                opcode;
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                      found;
        logic signed [VALUE_W-1:0] result_value;
        logic                      pool_full;
    } t_rsp;

    typedef struct packed {
        logic               present;
        logic [VALUE_W-1:0] value;
    } t_leaf;

endpackage

// File: sv/mtl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/multibit_trie_lookup.sv
// Multibit trie lookup: sequencer walking a shared child-table memory port.
//
// Each command walks the trie one level per cycle through a single read port
// of the child table, top key digit first. Search and delete read the leaf
// store after the last level, and end early when the walk hits a missing
// child. An insert walks the existing prefix and then writes one new child
// link per cycle for the remaining levels; an insert refused for lack of free
// nodes ends as soon as the walk meets the first missing child. Opcode three
// is a no-op whose all-zero result comes in the next cycle without raising
// busy. After reset, busy stays high while the child table and the leaf store
// are swept to zero. Each result is shown for exactly one cycle with o_valid
// and must be taken then: the receiver cannot stall it.
module multibit_trie_lookup #(
    parameter int NODE_COUNT = 1024,
    parameter int STRIDE     = 4,
    parameter int LEVELS     = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  mtl_pkg::t_req i_req,
    output logic          busy,
    output logic          o_valid,
    output mtl_pkg::t_rsp o_rsp
);

    localparam int NW          = $clog2(NODE_COUNT);
    localparam int CHILD_DEPTH = NODE_COUNT * (2 ** STRIDE);
    localparam int AW          = NW + STRIDE;
    localparam int FW          = $clog2(NODE_COUNT + 1);
    localparam int LW          = $clog2(LEVELS + 1);
    localparam int KW          = STRIDE * LEVELS;
    localparam int CW          = ((FW > LW) ? FW : LW) + 1;
    localparam int LEAF_W      = $bits(mtl_pkg::t_leaf);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_ALLOC,
        S_LEAF
    } t_state;

    t_state                                 r_state, n_state;
    logic [AW-1:0]                          r_clr, n_clr;
    logic [1:0]                             r_op, n_op;
    logic [KW-1:0]                          r_keysh, n_keysh;
    logic signed [mtl_pkg::VALUE_W-1:0]     r_val, n_val;
    logic [NW-1:0]                          r_node, n_node;
    logic [LW-1:0]                          r_level, n_level;
    logic [FW-1:0]                          r_next, n_next;
    logic                                   r_valid, n_valid;
    mtl_pkg::t_rsp                          r_rsp, n_rsp;

    logic [KW-1:0]   w_key_in;
    logic [KW-1:0]   w_key_next;
    logic            w_last;
    logic            w_short;

    logic            c_we;
    logic [AW-1:0]   c_waddr;
    logic [NW-1:0]   c_wdata;
    logic [AW-1:0]   c_raddr;
    logic [NW-1:0]   c_rdata;

    logic            l_we;
    logic [NW-1:0]   l_waddr;
    mtl_pkg::t_leaf  l_wdata;
    logic [LEAF_W-1:0] l_rdata_raw;
    mtl_pkg::t_leaf  l_rdata;

    assign w_key_in   = KW'(i_req.key);
    assign w_key_next = r_keysh << STRIDE;
    assign w_last     = (r_level == LW'(LEVELS - 1));
    assign w_short    = (CW'(LEVELS) + CW'(r_next)) > (CW'(NODE_COUNT) + CW'(r_level));

    assign c_raddr = (r_state == S_IDLE) ? {{NW{1'b0}}, w_key_in[KW-1 -: STRIDE]}
                                         : {c_rdata, w_key_next[KW-1 -: STRIDE]};
    assign l_rdata = l_rdata_raw;

    mtl_ram #(
        .WIDTH (NW),
        .DEPTH (CHILD_DEPTH)
    ) u_child (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    mtl_ram #(
        .WIDTH (LEAF_W),
        .DEPTH (NODE_COUNT)
    ) u_leaf (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (c_rdata),
        .o_rdata (l_rdata_raw)
    );

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_op    = r_op;
        n_keysh = r_keysh;
        n_val   = r_val;
        n_node  = r_node;
        n_level = r_level;
        n_next  = r_next;
        n_valid = 1'b0;
        n_rsp   = '0;
        c_we    = 1'b0;
        c_waddr = {r_node, r_keysh[KW-1 -: STRIDE]};
        c_wdata = r_next[NW-1:0];
        l_we    = 1'b0;
        l_waddr = r_node;
        l_wdata.present = 1'b1;
        l_wdata.value   = r_val;
        case (r_state)
            S_CLEAR: begin
                c_we    = 1'b1;
                c_waddr = r_clr;
                c_wdata = '0;
                l_we    = 1'b1;
                l_waddr = r_clr[AW-1:STRIDE];
                l_wdata = '0;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(CHILD_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op    = i_req.opcode;
                    n_keysh = w_key_in;
                    n_val   = i_req.value;
                    n_node  = '0;
                    n_level = '0;
                    if (i_req.opcode == mtl_pkg::OP_NOP) begin
                        n_valid = 1'b1;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (c_rdata == '0) begin
                    if (r_op == mtl_pkg::OP_INSERT) begin
                        if (w_short) begin
                            n_state         = S_IDLE;
                            n_valid         = 1'b1;
                            n_rsp.pool_full = 1'b1;
                        end else begin
                            n_state = S_ALLOC;
                        end
                    end else begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                        if (r_op == mtl_pkg::OP_SEARCH) begin
                            n_rsp.result_value = mtl_pkg::NOT_FOUND_VALUE;
                        end
                    end
                end else begin
                    n_node = c_rdata;
                    if (w_last) begin
                        n_state = S_LEAF;
                    end else begin
                        n_keysh = w_key_next;
                        n_level = r_level + LW'(1);
                    end
                end
            end
            S_ALLOC: begin
                c_we   = 1'b1;
                n_node = r_next[NW-1:0];
                n_next = r_next + FW'(1);
                if (w_last) begin
                    l_we        = 1'b1;
                    l_waddr     = r_next[NW-1:0];
                    n_state     = S_IDLE;
                    n_valid     = 1'b1;
                    n_rsp.found = 1'b1;
                end else begin
                    n_keysh = w_key_next;
                    n_level = r_level + LW'(1);
                end
            end
            S_LEAF: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                case (r_op)
                    mtl_pkg::OP_INSERT: begin
                        l_we        = 1'b1;
                        n_rsp.found = 1'b1;
                    end
                    mtl_pkg::OP_SEARCH: begin
                        if (l_rdata.present) begin
                            n_rsp.found        = 1'b1;
                            n_rsp.result_value = $signed(l_rdata.value);
                        end else begin
                            n_rsp.result_value = mtl_pkg::NOT_FOUND_VALUE;
                        end
                    end
                    mtl_pkg::OP_DELETE: begin
                        if (l_rdata.present) begin
                            l_we            = 1'b1;
                            l_wdata.present = 1'b0;
                            l_wdata.value   = l_rdata.value;
                            n_rsp.found     = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_next  <= FW'(1);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_next  <= n_next;
            r_valid <= n_valid;
        end
        r_op    <= n_op;
        r_keysh <= n_keysh;
        r_val   <= n_val;
        r_node  <= n_node;
        r_level <= n_level;
        r_rsp   <= n_rsp;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// File: sv/mtl_check.sv
// Port-level checker for the multibit trie lookup, bound to the top level.
`include "multibit_trie_lookup_macros.svh"

module mtl_check (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input mtl_pkg::t_req i_req,
    input logic          busy,
    input logic          o_valid,
    input mtl_pkg::t_rsp o_rsp
);

    logic w_accept;

    assign w_accept = start && !busy;

    `MTL_ASSERT_NXT(a_walk_holds_busy, i_clk, i_rst_n, w_accept && (i_req.opcode != mtl_pkg::OP_NOP), busy && !o_valid, "command accepted without raising busy")
    `MTL_ASSERT_NXT(a_nop_zero_beat, i_clk, i_rst_n, w_accept && (i_req.opcode == mtl_pkg::OP_NOP), o_valid && (o_rsp == '0), "no-op beat missing or nonzero")
    `MTL_ASSERT_NOW(a_full_clean, i_clk, i_rst_n, o_valid && o_rsp.pool_full, !o_rsp.found && (o_rsp.result_value == '0), "refused insert reports found or value")
    `MTL_ASSERT_NOW(a_beat_has_cause, i_clk, i_rst_n, o_valid, $past(busy) || $past(w_accept), "result beat without a command")

endmodule

bind multibit_trie_lookup mtl_check u_mtl_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_req   (i_req),
    .busy    (busy),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);

// File: verif/multibit_trie_lookup_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the multibit trie lookup block: directed table, then random traffic.
module multibit_trie_lookup_tb;

    localparam int TRIE_NODES   = 1024;
    localparam int DIGIT_BITS   = 4;
    localparam int DEPTH        = 8;
    localparam int FANOUT       = 1 << DIGIT_BITS;
    localparam int LINK_W       = $clog2(TRIE_NODES);
    localparam int RANDOM_BEATS = 1830;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIVE_KEY_CAP = 256;

    localparam mtl_pkg::t_rsp RSP_NONE = {1'b0, 32'h0000_0000, 1'b0};
    localparam mtl_pkg::t_rsp RSP_MISS = {1'b0, mtl_pkg::NOT_FOUND_VALUE, 1'b0};
    localparam mtl_pkg::t_rsp RSP_DONE = {1'b1, 32'h0000_0000, 1'b0};

    typedef struct packed {
        mtl_pkg::t_req req;
        logic          fixed_rsp;
        mtl_pkg::t_rsp rsp;
    } t_dir_row;

    localparam int DIR_ROWS = 23;

    t_dir_row dir_rows [DIR_ROWS] = '{
        {mtl_pkg::OP_SEARCH, 32'h0000_0000, 32'h0000_0000, 1'b1, RSP_MISS},
        {mtl_pkg::OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1, RSP_NONE},
        {mtl_pkg::OP_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, RSP_NONE},
        {mtl_pkg::OP_INSERT, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, RSP_DONE},
        {mtl_pkg::OP_SEARCH, 32'h0000_0000, 32'h0000_0000, 1'b0, RSP_NONE},
        {mtl_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, RSP_DONE},
        {mtl_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, RSP_NONE},
        {mtl_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, RSP_DONE},
        {mtl_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, RSP_NONE},
        {mtl_pkg::OP_INSERT, 32'h0000_000F, 32'h0000_0000, 1'b1, RSP_DONE},
        {mtl_pkg::OP_SEARCH, 32'h0000_000E, 32'h1234_5678, 1'b1, RSP_MISS},
        {mtl_pkg::OP_DELETE, 32'h0000_000F, 32'h0000_0000, 1'b0, RSP_NONE},
        {mtl_pkg::OP_DELETE, 32'h0000_000F, 32'h0000_0000, 1'b1, RSP_NONE},
        {mtl_pkg::OP_SEARCH, 32'h0000_000F, 32'h0000_0000, 1'b0, RSP_NONE},
        {mtl_pkg::OP_INSERT, 32'h0000_000F, 32'hA5A5_A5A5, 1'b1, RSP_DONE},
        {mtl_pkg::OP_SEARCH, 32'h0000_000F, 32'h0000_0000, 1'b0, RSP_NONE},
        {mtl_pkg::OP_SEARCH, 32'h8000_0000, 32'h0000_0000, 1'b1, RSP_MISS},
        {mtl_pkg::OP_DELETE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, RSP_NONE},
        {mtl_pkg::OP_INSERT, 32'h1234_5678, 32'h5A5A_5A5A, 1'b0, RSP_NONE},
        {mtl_pkg::OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, RSP_NONE},
        {mtl_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, RSP_MISS},
        {mtl_pkg::OP_NOP,    32'h0000_0000, 32'h0000_0000, 1'b1, RSP_NONE},
        {mtl_pkg::OP_SEARCH, 32'h1234_5678, 32'h0000_0000, 1'b0, RSP_NONE}
    };

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic          o_valid;
    mtl_pkg::t_req i_req;
    mtl_pkg::t_rsp o_rsp;

    logic [LINK_W-1:0]           child_link [TRIE_NODES*FANOUT];
    logic                        leaf_on    [TRIE_NODES];
    logic [mtl_pkg::VALUE_W-1:0] leaf_val   [TRIE_NODES];
    logic [LINK_W:0]             free_node;

    mtl_pkg::t_rsp             pending_rsp [$];
    logic [mtl_pkg::KEY_W-1:0] live_keys   [$];
    logic [mtl_pkg::KEY_W-1:0] key_bases   [4];

    int errors;
    int beats_sent;
    int beats_seen;
    int hits_seen;
    int refusals_seen;
    int burst_left;

    multibit_trie_lookup #(
        .NODE_COUNT(TRIE_NODES),
        .STRIDE    (DIGIT_BITS),
        .LEVELS    (DEPTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[multibit_trie_lookup] ERROR");
        $finish;
    end

    function automatic int digit_of(input logic [mtl_pkg::KEY_W-1:0] key, input int level);
        int shift;
        shift = DIGIT_BITS * (DEPTH - 1 - level);
        if (shift >= mtl_pkg::KEY_W) return 0;
        return int'((key >> shift) & (FANOUT - 1));
    endfunction

    function automatic int slot_of(input int node, input int dig);
        return (node % TRIE_NODES) * FANOUT + dig;
    endfunction

    function automatic bit walk_path(input logic [mtl_pkg::KEY_W-1:0] key, output int last);
        int node;
        node = 0;
        last = 0;
        for (int lvl = 0; lvl < DEPTH; lvl++) begin
            node = int'(child_link[slot_of(node, digit_of(key, lvl))]);
            if (node == 0) return 1'b0;
        end
        last = node % TRIE_NODES;
        return 1'b1;
    endfunction

    function automatic mtl_pkg::t_rsp trie_apply(input mtl_pkg::t_req req);
        mtl_pkg::t_rsp rsp;
        int            node;
        int            nxt;
        int            missing;
        int            s;
        rsp = RSP_NONE;
        case (req.opcode)
            mtl_pkg::OP_INSERT: begin
                node    = 0;
                missing = 0;
                for (int lvl = 0; lvl < DEPTH; lvl++) begin
                    nxt = int'(child_link[slot_of(node, digit_of(req.key, lvl))]);
                    if (nxt == 0) begin
                        missing = DEPTH - lvl;
                        break;
                    end
                    node = nxt;
                end
                if (missing > TRIE_NODES - int'(free_node)) begin
                    rsp.pool_full = 1'b1;
                end else begin
                    node = 0;
                    for (int lvl = 0; lvl < DEPTH; lvl++) begin
                        s = slot_of(node, digit_of(req.key, lvl));
                        if (child_link[s] == '0) begin
                            child_link[s] = free_node[LINK_W-1:0];
                            free_node     = free_node + (LINK_W+1)'(1);
                        end
                        node = int'(child_link[s]);
                    end
                    node           = node % TRIE_NODES;
                    leaf_on[node]  = 1'b1;
                    leaf_val[node] = req.value;
                    rsp.found      = 1'b1;
                end
            end
            mtl_pkg::OP_SEARCH: begin
                rsp.result_value = mtl_pkg::NOT_FOUND_VALUE;
                if (walk_path(req.key, node) && leaf_on[node]) begin
                    rsp.found        = 1'b1;
                    rsp.result_value = leaf_val[node];
                end
            end
            mtl_pkg::OP_DELETE: begin
                if (walk_path(req.key, node) && leaf_on[node]) begin
                    leaf_on[node] = 1'b0;
                    rsp.found     = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    task automatic send_cmd(input mtl_pkg::t_req req, input logic fixed_rsp,
                            input mtl_pkg::t_rsp typed_rsp);
        mtl_pkg::t_rsp predicted;
        int            gap;
        if (burst_left > 0) begin
            gap        = 0;
            burst_left = burst_left - 1;
        end else begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        predicted = trie_apply(req);
        pending_rsp.push_back(fixed_rsp ? typed_rsp : predicted);
        beats_sent++;
    endtask

    always @(posedge i_clk) begin
        mtl_pkg::t_rsp want;
        if (i_rst_n && o_valid) begin
            beats_seen++;
            if (o_rsp.found) hits_seen++;
            if (o_rsp.pool_full) refusals_seen++;
            if (pending_rsp.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected: %p", $time, o_rsp);
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.found !== want.found) begin
                    errors++;
                    $display("%0t: found expected %0b actual %0b", $time, want.found,
                             o_rsp.found);
                end
                if (o_rsp.result_value !== want.result_value) begin
                    errors++;
                    $display("%0t: result_value expected %0d actual %0d", $time,
                             want.result_value, o_rsp.result_value);
                end
                if (o_rsp.pool_full !== want.pool_full) begin
                    errors++;
                    $display("%0t: pool_full expected %0b actual %0b", $time,
                             want.pool_full, o_rsp.pool_full);
                end
            end
        end
    end

    initial begin
        mtl_pkg::t_req req;
        int            pick;
        int            random_done;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_req         = '0;
        errors        = 0;
        beats_sent    = 0;
        beats_seen    = 0;
        hits_seen     = 0;
        refusals_seen = 0;
        burst_left    = 0;
        free_node     = (LINK_W+1)'(1);
        foreach (child_link[i]) child_link[i] = '0;
        foreach (leaf_on[i]) begin
            leaf_on[i]  = 1'b0;
            leaf_val[i] = '0;
        end
        foreach (key_bases[i]) key_bases[i] = $urandom;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_cmd(dir_rows[i].req, dir_rows[i].fixed_rsp, dir_rows[i].rsp);

        random_done = 0;
        while (random_done < RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      req.opcode = mtl_pkg::OP_INSERT;
            else if (pick < 75) req.opcode = mtl_pkg::OP_SEARCH;
            else if (pick < 96) req.opcode = mtl_pkg::OP_DELETE;
            else                req.opcode = mtl_pkg::OP_NOP;

            pick = $urandom_range(0, 99);
            if (pick < 40 && live_keys.size() > 0)
                req.key = live_keys[$urandom_range(0, live_keys.size() - 1)];
            else if (pick < 88)
                req.key = {key_bases[$urandom_range(0, 3)][mtl_pkg::KEY_W-1:12],
                           12'($urandom_range(0, 4095))};
            else
                req.key = $urandom;

            case ($urandom_range(0, 19))
                0:       req.value = 32'h8000_0000;
                1:       req.value = 32'h7FFF_FFFF;
                2:       req.value = 32'h0000_0000;
                3:       req.value = 32'hFFFF_FFFF;
                default: req.value = $urandom;
            endcase

            if (req.opcode == mtl_pkg::OP_INSERT && live_keys.size() < LIVE_KEY_CAP)
                live_keys.push_back(req.key);
            random_done++;
            send_cmd(req, 1'b0, RSP_NONE);
        end
        start <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Issued %0d commands, checked %0d result beats.", beats_sent, beats_seen);
        $display("Hits or successful updates: %0d; inserts refused with pool exhausted: %0d.",
                 hits_seen, refusals_seen);
        if (errors == 0) begin
            $display("[multibit_trie_lookup] OK");
        end else begin
            $display("[multibit_trie_lookup] ERROR");
        end
        $finish;
    end

endmodule
